@@ hw/rtl/ucb_pkg.sv @@
// ----------------------------------------------------------------------------
// UCB arm selector package
// Shared widths, function codes, state encoding and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package ucb_pkg;

	localparam int NUM_ARMS = 5;
	localparam int IDX_W    = $clog2(NUM_ARMS);
	localparam int ARM_W    = 3;
	localparam int SUM_W    = 48;
	localparam int CNT_W    = 32;
	localparam int TOT_W    = CNT_W + $clog2(NUM_ARMS) + 1;
	localparam int LG_W     = 22;
	localparam int DIV_N    = 48;
	localparam int DIV_CW   = $clog2(DIV_N);
	localparam logic [15:0] GAIN_RESET = 16'd256;
	localparam logic [15:0] LN2_Q16    = 16'd45426;

	// transaction function codes
	localparam logic FN_SELECT = 1'b0;
	localparam logic FN_REPORT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_NORM,
		ST_LOG_MUL,
		ST_LOG_STEP,
		ST_LN_MUL,
		ST_LN_HOLD,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_RATIO_GO,
		ST_RATIO_WAIT,
		ST_SQRT,
		ST_EXPL_MUL,
		ST_SCORE,
		ST_UPDATE,
		ST_DONE
	} ucb_state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_N-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_N-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ucb_div.sv @@
// ----------------------------------------------------------------------------
// UCB serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_div (
	input  wire               clk,
	input  wire               arst_n,
	input  ucb_pkg::div_req_t req,
	output ucb_pkg::div_rsp_t rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [ucb_pkg::DIV_CW-1:0]  cnt_q;
	logic [ucb_pkg::CNT_W-1:0]   rem_q;
	logic [ucb_pkg::CNT_W-1:0]   dvs_q;
	logic [ucb_pkg::DIV_N-1:0]   quo_q;
	logic [ucb_pkg::CNT_W:0]     rem_sh;
	logic                        ge;
	logic [ucb_pkg::CNT_W:0]     rem_sub;

	assign rem_sh  = {rem_q, quo_q[ucb_pkg::DIV_N-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ucb_pkg::DIV_CW'(ucb_pkg::DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[ucb_pkg::CNT_W-1:0] : rem_sh[ucb_pkg::CNT_W-1:0];
			quo_q <= {quo_q[ucb_pkg::DIV_N-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

`ifndef SYNTHESIS
	a_no_restart : assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");
	a_done_pulse : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ucb_arm_selector.sv @@
// Sequence: a report transaction is absorbed in the cycle it is accepted; a select
//   transaction with an unpicked arm goes from the scan straight to the update,
//   otherwise it runs the scan, normalisation, 16 log rounds, then two serial
//   divisions and a 19-step root per arm, and the update.
// Throughput: one select at a time; ready is low until its result is registered.
// Reset (arst_n low): gain = 1.0, all reward sums and pick counts cleared at once.
// ----------------------------------------------------------------------------
// UCB arm selector
// UCB1 bandit: reward reports and arm selection on a shared serial datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_arm_selector (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         func,
	input  wire  [2:0]  arm_index,
	input  wire  [31:0] reward,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  selected_arm
);

	localparam logic [37:0] SQ_START = 38'h10_0000_0000;

	ucb_pkg::ucb_state_t state_q, state_d;

	logic [15:0]                gain_q;
	logic [ucb_pkg::SUM_W-1:0]  sum_q [ucb_pkg::NUM_ARMS];
	logic [ucb_pkg::CNT_W-1:0]  cnt_q [ucb_pkg::NUM_ARMS];

	logic [ucb_pkg::IDX_W-1:0]  arm_q;
	logic [ucb_pkg::IDX_W-1:0]  best_q;
	logic [ucb_pkg::TOT_W-1:0]  total_q;
	logic [ucb_pkg::TOT_W-1:0]  norm_q;
	logic [5:0]                 exp_q;
	logic [31:0]                y_q;
	logic [15:0]                frac_q;
	logic [3:0]                 rnd_q;
	logic [63:0]                mul_q;
	logic [ucb_pkg::LG_W-1:0]   ln_q;
	logic                       neg_q;
	logic signed [48:0]         mean_q;
	logic [37:0]                v_q;
	logic [37:0]                res_q;
	logic [37:0]                bit_q;
	logic signed [49:0]         best_score_q;
	logic                       out_valid_q;
	logic [2:0]                 sel_q;

	logic                       last_arm;
	logic [ucb_pkg::CNT_W-1:0]  cur_cnt;
	logic [ucb_pkg::SUM_W-1:0]  cur_sum;
	logic [ucb_pkg::SUM_W-1:0]  sum_mag;
	logic [ucb_pkg::TOT_W-1:0]  total_next;
	logic [31:0]                mul_a, mul_b;
	logic [32:0]                sq;
	logic [38:0]                rb;
	logic                       sq_ge;
	logic signed [49:0]         score;
	logic signed [48:0]         acc;
	logic [ucb_pkg::SUM_W-1:0]  acc_sat;
	logic                       in_acc;
	logic                       out_free;
	logic [ucb_pkg::IDX_W-1:0]  rep_idx;

	ucb_pkg::div_req_t div_req;
	ucb_pkg::div_rsp_t div_rsp;

	assign last_arm   = arm_q == ucb_pkg::IDX_W'(ucb_pkg::NUM_ARMS - 1);
	assign cur_cnt    = cnt_q[arm_q];
	assign cur_sum    = sum_q[arm_q];
	assign sum_mag    = cur_sum[ucb_pkg::SUM_W-1] ? (~cur_sum + 1'b1) : cur_sum;
	assign total_next = total_q + ucb_pkg::TOT_W'(cur_cnt);
	assign sq         = mul_q[63:31];
	assign rb         = {1'b0, res_q} + {1'b0, bit_q};
	assign sq_ge      = {1'b0, v_q} >= rb;
	// mean plus the explore term, the product shifted down by eight
	assign score      = {mean_q[48], mean_q} + $signed({23'b0, mul_q[34:8]});
	assign in_acc     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign rep_idx    = ucb_pkg::IDX_W'(arm_index);

	// Saturating accumulate of a signed reward into a 48-bit sum
	assign acc = {sum_q[rep_idx][ucb_pkg::SUM_W-1], sum_q[rep_idx]}
		+ {{17{reward[31]}}, reward};
	always_comb begin
		if (acc[48] != acc[47]) begin
			acc_sat = acc[48] ? {1'b1, {(ucb_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(ucb_pkg::SUM_W-1){1'b1}}};
		end else begin
			acc_sat = acc[ucb_pkg::SUM_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ucb_pkg::ST_IDLE: begin
				if (in_valid && func == ucb_pkg::FN_SELECT) state_d = ucb_pkg::ST_SCAN;
			end
			ucb_pkg::ST_SCAN: begin
				if (cur_cnt == '0) state_d = ucb_pkg::ST_UPDATE;
				else if (last_arm) state_d = ucb_pkg::ST_NORM;
			end
			ucb_pkg::ST_NORM: begin
				if (norm_q[ucb_pkg::TOT_W-1]) state_d = ucb_pkg::ST_LOG_MUL;
			end
			ucb_pkg::ST_LOG_MUL:    state_d = ucb_pkg::ST_LOG_STEP;
			ucb_pkg::ST_LOG_STEP: begin
				state_d = (rnd_q == 4'd15) ? ucb_pkg::ST_LN_MUL : ucb_pkg::ST_LOG_MUL;
			end
			ucb_pkg::ST_LN_MUL:     state_d = ucb_pkg::ST_LN_HOLD;
			ucb_pkg::ST_LN_HOLD:    state_d = ucb_pkg::ST_MEAN_GO;
			ucb_pkg::ST_MEAN_GO:    state_d = ucb_pkg::ST_MEAN_WAIT;
			ucb_pkg::ST_MEAN_WAIT:  if (div_rsp.done) state_d = ucb_pkg::ST_RATIO_GO;
			ucb_pkg::ST_RATIO_GO:   state_d = ucb_pkg::ST_RATIO_WAIT;
			ucb_pkg::ST_RATIO_WAIT: if (div_rsp.done) state_d = ucb_pkg::ST_SQRT;
			ucb_pkg::ST_SQRT:       if (bit_q[0]) state_d = ucb_pkg::ST_EXPL_MUL;
			ucb_pkg::ST_EXPL_MUL:   state_d = ucb_pkg::ST_SCORE;
			ucb_pkg::ST_SCORE: begin
				state_d = last_arm ? ucb_pkg::ST_UPDATE : ucb_pkg::ST_MEAN_GO;
			end
			ucb_pkg::ST_UPDATE:     state_d = ucb_pkg::ST_DONE;
			ucb_pkg::ST_DONE:       if (out_free) state_d = ucb_pkg::ST_IDLE;
			default:                state_d = ucb_pkg::ST_IDLE;
		endcase
	end

	// Control outputs: handshake, divider requests, shared multiplier operands
	always_comb begin
		in_ready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {ucb_pkg::DIV_N{1'b0}};
		div_req.divisor  = cur_cnt;
		mul_a            = y_q;
		mul_b            = y_q;
		unique case (state_q)
			ucb_pkg::ST_IDLE:     in_ready = 1'b1;
			ucb_pkg::ST_MEAN_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = sum_mag;
			end
			ucb_pkg::ST_RATIO_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = ucb_pkg::DIV_N'(ln_q);
			end
			ucb_pkg::ST_LN_MUL: begin
				mul_a = 32'({exp_q, frac_q});
				mul_b = 32'(ucb_pkg::LN2_Q16);
			end
			ucb_pkg::ST_EXPL_MUL: begin
				mul_a = 32'(gain_q);
				mul_b = 32'(res_q[18:0]);
			end
			default: ;
		endcase
	end

	ucb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Control state, configuration and the arm tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ucb_pkg::ST_IDLE;
			gain_q      <= ucb_pkg::GAIN_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ucb_pkg::NUM_ARMS; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) gain_q <= cfg_wr_data;
			// drop the result once taken, load a new one in the done state
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == ucb_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
			// report: accumulate into an arm in range, ignore others
			if (in_acc && func == ucb_pkg::FN_REPORT
				&& int'(arm_index) < ucb_pkg::NUM_ARMS) begin
				sum_q[rep_idx] <= acc_sat;
			end
			// count the chosen arm, holding at full scale
			if (state_q == ucb_pkg::ST_UPDATE && cnt_q[best_q] != '1) begin
				cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (state_q)
			ucb_pkg::ST_IDLE: begin
				arm_q   <= '0;
				total_q <= '0;
			end
			ucb_pkg::ST_SCAN: begin
				total_q <= total_next;
				norm_q  <= total_next + 1'b1;
				exp_q   <= 6'(ucb_pkg::TOT_W - 1);
				best_q  <= arm_q;
				arm_q   <= arm_q + 1'b1;
			end
			ucb_pkg::ST_NORM: begin
				// normalise: shift up until the leading one reaches the top
				if (norm_q[ucb_pkg::TOT_W-1]) begin
					y_q    <= norm_q[ucb_pkg::TOT_W-1 -: 32];
					rnd_q  <= '0;
					frac_q <= '0;
				end else begin
					norm_q <= norm_q << 1;
					exp_q  <= exp_q - 1'b1;
				end
			end
			ucb_pkg::ST_LOG_STEP: begin
				// one fraction bit per squaring
				frac_q <= {frac_q[14:0], sq[32]};
				y_q    <= sq[32] ? sq[32:1] : sq[31:0];
				rnd_q  <= rnd_q + 1'b1;
			end
			ucb_pkg::ST_LN_HOLD: begin
				ln_q  <= mul_q[16 +: ucb_pkg::LG_W];
				arm_q <= '0;
			end
			ucb_pkg::ST_MEAN_GO: neg_q <= cur_sum[ucb_pkg::SUM_W-1];
			ucb_pkg::ST_MEAN_WAIT: begin
				if (div_rsp.done) begin
					mean_q <= neg_q ? -$signed({1'b0, div_rsp.quotient})
						: $signed({1'b0, div_rsp.quotient});
				end
			end
			ucb_pkg::ST_RATIO_WAIT: begin
				if (div_rsp.done) begin
					v_q   <= {div_rsp.quotient[21:0], 16'b0};
					res_q <= '0;
					bit_q <= SQ_START;
				end
			end
			ucb_pkg::ST_SQRT: begin
				if (sq_ge) begin
					v_q   <= v_q - rb[37:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ucb_pkg::ST_SCORE: begin
				// strict compare keeps the lower index on a tie
				if (arm_q == '0 || score > best_score_q) begin
					best_score_q <= score;
					best_q       <= arm_q;
				end
				arm_q <= arm_q + 1'b1;
			end
			ucb_pkg::ST_DONE: if (out_free) sel_q <= 3'(best_q);
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign selected_arm = sel_q;

`ifndef SYNTHESIS
	a_sel_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> int'(sel_q) < ucb_pkg::NUM_ARMS)
		else $error("selected arm out of range");
	a_select_busy : assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && func == ucb_pkg::FN_SELECT |=> !in_ready)
		else $error("ready after a select transaction");
	a_count_mono : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] >= $past(cnt_q[0]))
		else $error("pick count decreased");
	a_div_idle_start : assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("division requested while busy");
`endif

endmodule

`default_nettype wire

@@ tb/sv/ucb_arm_selector_chk.sv @@
// ----------------------------------------------------------------------------
// UCB arm selector checker
// Watches the input, output and register ports, keeps a bit-exact model of
// the arm statistics and compares every selected arm with the prediction.
// ----------------------------------------------------------------------------

module ucb_arm_selector_chk (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire         func,
	input  wire  [2:0]  arm_index,
	input  wire  [31:0] reward,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [2:0]  selected_arm,
	output int          mismatch_count,
	output int          pending_picks,
	output int          select_count,
	output int          report_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -64'sh0000_8000_0000_0000;

	logic [15:0]   gain_q8;
	longint        arm_sum [ucb_pkg::NUM_ARMS];
	bit [ucb_pkg::CNT_W-1:0] arm_picks [ucb_pkg::NUM_ARMS];
	logic [2:0]    chosen_arm_q [$];

	function automatic longint unsigned log2_q16(input longint unsigned x);
		int unsigned e;
		longint unsigned y;
		longint unsigned frac;
		e = 0;
		frac = 0;
		while (e < 63 && (x >> (e + 1)) != 0)
			e++;
		y = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
		for (int k = 0; k < 16; k++) begin
			y = (y * y) >> 31;
			frac <<= 1;
			if (y >= 64'h1_0000_0000) begin
				frac |= 1;
				y >>= 1;
			end
		end
		return (longint'(e) << 16) | frac;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint arm_score(input int i, input longint unsigned ln_q16);
		longint mean;
		longint unsigned ratio;
		longint unsigned explore;
		mean = arm_sum[i] / longint'(arm_picks[i]);
		ratio = ln_q16 / longint'(arm_picks[i]);
		explore = (longint'(gain_q8) * int_sqrt(ratio << 16)) >> 8;
		return mean + longint'(explore);
	endfunction

	// Unpicked arms first, then the strictly best score; bumps the count.
	function automatic logic [2:0] pick_arm();
		longint unsigned total;
		longint unsigned ln_q16;
		longint best_score;
		longint sc;
		int best;
		total = 0;
		best = 0;
		for (int i = 0; i < ucb_pkg::NUM_ARMS; i++) begin
			if (arm_picks[i] == 0) begin
				arm_picks[i] = 1;
				return 3'(i);
			end
			total += arm_picks[i];
		end
		ln_q16 = (log2_q16(total + 1) * longint'(ucb_pkg::LN2_Q16)) >> 16;
		best_score = arm_score(0, ln_q16);
		for (int i = 1; i < ucb_pkg::NUM_ARMS; i++) begin
			sc = arm_score(i, ln_q16);
			if (sc > best_score) begin
				best_score = sc;
				best = i;
			end
		end
		if (arm_picks[best] != '1)
			arm_picks[best]++;
		return 3'(best);
	endfunction

	function automatic void add_reward(input logic [2:0] arm, input logic [31:0] r);
		longint s;
		if (arm >= ucb_pkg::NUM_ARMS)
			return;
		s = arm_sum[arm] + longint'(signed'(r));
		if (s > SUM_HI)
			s = SUM_HI;
		if (s < SUM_LO)
			s = SUM_LO;
		arm_sum[arm] = s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q8 = ucb_pkg::GAIN_RESET;
			for (int i = 0; i < ucb_pkg::NUM_ARMS; i++) begin
				arm_sum[i] = 0;
				arm_picks[i] = 0;
			end
			chosen_arm_q.delete();
			mismatch_count = 0;
			select_count = 0;
			report_count = 0;
		end else begin
			if (cfg_wr_en)
				gain_q8 = cfg_wr_data;
			// compare first: a result never belongs to the transaction of this edge
			if (out_valid && out_ready) begin
				if (chosen_arm_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result, selected_arm=%0d",
							$realtime, selected_arm);
				end else if (selected_arm !== chosen_arm_q[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: selected_arm mismatch: expected %0d, got %0d",
							$realtime, chosen_arm_q[0], selected_arm);
					void'(chosen_arm_q.pop_front());
				end else begin
					void'(chosen_arm_q.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				if (func == ucb_pkg::FN_SELECT) begin
					chosen_arm_q.push_back(pick_arm());
					select_count++;
				end else begin
					add_reward(arm_index, reward);
					report_count++;
				end
			end
		end
		pending_picks = chosen_arm_q.size();
	end

endmodule

@@ tb/sv/ucb_arm_selector_tb.sv @@
// ----------------------------------------------------------------------------
// UCB arm selector testbench
// Drives reward reports and arm selections with random idling on both sides
// over several exploration gains, and leaves all checking to the checker.
// ----------------------------------------------------------------------------

module ucb_arm_selector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// a full scoring pass over all arms, with margin
	localparam int SETTLE_CYCLES = ucb_pkg::NUM_ARMS * 120 + 200;
	localparam int HOLDOFF_CYCLES = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        func = ucb_pkg::FN_SELECT;
	logic [2:0]  arm_index = '0;
	logic [31:0] reward = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [2:0]  selected_arm;

	int mismatch_count;
	int pending_picks;
	int select_count;
	int report_count;
	bit stim_done = 1'b0;

	always #5 clk = ~clk;

	ucb_arm_selector dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .arm_index(arm_index), .reward(reward),
		.out_valid(out_valid), .out_ready(out_ready), .selected_arm(selected_arm)
	);

	ucb_arm_selector_chk chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .arm_index(arm_index), .reward(reward),
		.out_valid(out_valid), .out_ready(out_ready), .selected_arm(selected_arm),
		.mismatch_count(mismatch_count), .pending_picks(pending_picks),
		.select_count(select_count), .report_count(report_count)
	);

	// Mostly back-to-back, sometimes a short pause, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 11)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one transaction and hold it until the block takes it. With no gap
	// the valid simply stays high for the next transaction.
	task automatic offer(input logic fn, input logic [2:0] arm, input logic [31:0] r,
			input int gap);
		in_valid <= 1'b1;
		func <= fn;
		arm_index <= arm;
		reward <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain all outstanding selections, then let the datapath settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_picks != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(input logic [15:0] g);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= g;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random phase: mostly in-range reports with rewards of mixed magnitude,
	// some selections, and a few reports to non-existent arms.
	task automatic random_phase(input int n);
		logic [31:0] r;
		logic [2:0]  arm;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: r = $urandom();
				1: r = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
				default: r = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 16));
			endcase
			arm = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, ucb_pkg::NUM_ARMS - 1));
			if ($urandom_range(0, 9) < 3)
				offer(ucb_pkg::FN_SELECT, 3'($urandom()), $urandom(), idle_len());
			else
				offer(ucb_pkg::FN_REPORT, arm, r, idle_len());
		end
	endtask

	// Receiver: random stalls, plus one long hold-off early on so the block
	// fills up and holds its input ready low while the sender keeps offering.
	initial begin
		int hold;
		int idle;
		bit held;
		hold = 0;
		idle = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && select_count >= 12) begin
				held = 1'b1;
				hold = HOLDOFF_CYCLES;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (idle > 0) begin
				out_ready <= 1'b0;
				idle--;
			end else begin
				out_ready <= 1'b1;
				if (stim_done == 1'b0)
					idle = idle_len();
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill every unpicked arm, reward extremes, ignored arms.
		for (int i = 0; i < ucb_pkg::NUM_ARMS; i++)
			offer(ucb_pkg::FN_SELECT, 3'(i), '0, 0);
		offer(ucb_pkg::FN_REPORT, 3'd0, 32'h7FFF_FFFF, 1);
		offer(ucb_pkg::FN_REPORT, 3'd1, 32'h8000_0000, 0);
		offer(ucb_pkg::FN_REPORT, 3'd4, 32'h0000_0000, 2);
		offer(ucb_pkg::FN_REPORT, 3'd2, 32'h0000_0001, 0);
		offer(ucb_pkg::FN_REPORT, 3'd3, 32'hFFFF_FFFF, 0);
		offer(ucb_pkg::FN_REPORT, 3'd5, 32'h7FFF_FFFF, 0);
		offer(ucb_pkg::FN_REPORT, 3'd6, 32'h8000_0000, 0);
		offer(ucb_pkg::FN_REPORT, 3'd7, 32'h5555_AAAA, 0);
		for (int i = 0; i < 4; i++)
			offer(ucb_pkg::FN_SELECT, 3'(7 - i), 32'hFFFF_FFFF, idle_len());
		drain();

		// Sweep the exploration gain across its range.
		write_gain(16'h0000);
		random_phase(120);
		drain();
		write_gain(16'hFFFF);
		random_phase(120);
		drain();
		write_gain(16'($urandom()));
		random_phase(120);
		drain();
		write_gain(16'h0100);
		random_phase(120);
		drain();

		stim_done = 1'b1;
		$display("Covered %0d selections and %0d reward reports over five gain settings,",
			select_count, report_count);
		$display("including extreme rewards, ignored arms and a long output hold-off.");
		if (mismatch_count == 0 && pending_picks == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ucb_pkg.sv
hw/rtl/ucb_div.sv
hw/rtl/ucb_arm_selector.sv
tb/sv/ucb_arm_selector_chk.sv
tb/sv/ucb_arm_selector_tb.sv
